>>> hdl/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// shared types and status codes for the interval reservation table
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int TIME_W = 32;
    localparam int ENTRY_W = 2 * TIME_W;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [1:0] t_status;

    localparam t_status STATUS_BOOKED = 2'd0;
    localparam t_status STATUS_OVERLAP = 2'd1;
    localparam t_status STATUS_FULL = 2'd2;

endpackage

>>> hdl/irt_ram.sv
// ----------------------------------------------------------------------------
// irt_ram
// generic single-write, single-read synchronous ram with registered read data
// ----------------------------------------------------------------------------
module irt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/interval_reservation_table.sv
// ----------------------------------------------------------------------------
// interval_reservation_table
// books half-open time ranges, refusing any that clash with a stored range or that find the table full
// the o_done strobe follows a scan of the stored ranges, cut short by a clash;
//   a new request is taken only once the last is done (busy low), as the single
//   ram read port scans the stored ranges one per cycle
// reset: synchronous active low, empties the table (fill count to zero)
// results are strobed for one cycle and cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module interval_reservation_table #(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  irt_pkg::t_time        i_start_time,
    input  irt_pkg::t_time        i_end_time,
    output logic                  o_done,
    output irt_pkg::t_status      o_status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_SCAN = 1'b1;

    logic [0:0]             r_state, n_state;
    logic [CW-1:0]          r_fill, n_fill;
    logic [CW-1:0]          r_issue, n_issue;
    logic                   r_pend, n_pend;
    irt_pkg::t_time         r_lo, n_lo;
    irt_pkg::t_time         r_hi, n_hi;
    logic                   r_done, n_done;
    irt_pkg::t_status       r_status, n_status;

    logic                   w_accept;
    logic                   w_clash;
    logic                   w_we;
    logic [irt_pkg::ENTRY_W-1:0] w_rdata;
    irt_pkg::t_time         w_ent_lo;
    irt_pkg::t_time         w_ent_hi;

    irt_ram #(
        .WIDTH (irt_pkg::ENTRY_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata ({r_hi, r_lo}),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_accept = start && (r_state == S_IDLE);
    assign w_ent_lo = w_rdata[irt_pkg::TIME_W-1:0];
    assign w_ent_hi = w_rdata[irt_pkg::ENTRY_W-1:irt_pkg::TIME_W];
    assign w_clash  = r_pend && (r_lo < w_ent_hi) && (r_hi > w_ent_lo);

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_issue  = r_issue;
        n_pend   = 1'b0;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_done   = 1'b0;
        n_status = r_status;
        w_we     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                    n_issue = '0;
                    n_lo    = i_start_time;
                    n_hi    = i_end_time;
                end
            end
            S_SCAN: begin
                // issue one read a cycle, compare each entry returned in the cycle after its read
                if (r_issue != r_fill) begin
                    n_issue = r_issue + CW'(1);
                    n_pend  = 1'b1;
                end
                priority if (w_clash) begin
                    n_state  = S_IDLE;
                    n_pend   = 1'b0;
                    n_done   = 1'b1;
                    n_status = irt_pkg::STATUS_OVERLAP;
                end else if (r_issue == r_fill) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (r_fill == CW'(CAPACITY)) begin
                        n_status = irt_pkg::STATUS_FULL;
                    end else begin
                        n_status = irt_pkg::STATUS_BOOKED;
                        w_we     = 1'b1;
                        n_fill   = r_fill + CW'(1);
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_issue <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_issue <= n_issue;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_status <= n_status;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_status = r_status;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("not busy after accepting a request");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed while still scanning");

    a_booked_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == irt_pkg::STATUS_BOOKED)) |->
            (r_fill == $past(r_fill) + CW'(1)))
        else $error("booked beat without table growth");

    a_refused_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != irt_pkg::STATUS_BOOKED)) |-> $stable(r_fill))
        else $error("refused beat changed the table");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the interval reservation table: requests are driven
// through the start/busy handshake, each status strobe is checked against a
// behavioural booking table kept in the bench, covering boundary and empty or
// reversed ranges, clashes, filling to capacity and the full-table refusal
// ----------------------------------------------------------------------------
module testbench;

    localparam int CAPACITY = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    irt_pkg::t_time   i_start_time;
    irt_pkg::t_time   i_end_time;
    logic             o_done;
    irt_pkg::t_status o_status;

    irt_pkg::t_time   booked_start [CAPACITY];
    irt_pkg::t_time   booked_end [CAPACITY];
    int               booked_count;
    irt_pkg::t_status expected_status_q [$];
    irt_pkg::t_time   fresh_base;

    int      error_count;
    int      requests_sent;
    int      seen_booked;
    int      seen_overlap;
    int      seen_full;
    int      idle_cycles;

    interval_reservation_table #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_start_time(i_start_time),
        .i_end_time(i_end_time),
        .o_done(o_done),
        .o_status(o_status)
    );

    always #6 i_clk = ~i_clk;

    // booking rule: clash check over all stored ranges first, then room check
    function automatic irt_pkg::t_status predict_booking(input irt_pkg::t_time lo,
                                                         input irt_pkg::t_time hi);
        for (int i = 0; i < booked_count; i++) begin
            if (lo < booked_end[i] && hi > booked_start[i]) begin
                return irt_pkg::STATUS_OVERLAP;
            end
        end
        if (booked_count >= CAPACITY) begin
            return irt_pkg::STATUS_FULL;
        end
        booked_start[booked_count] = lo;
        booked_end[booked_count] = hi;
        booked_count++;
        return irt_pkg::STATUS_BOOKED;
    endfunction

    task automatic send_request(input irt_pkg::t_time lo, input irt_pkg::t_time hi);
        irt_pkg::t_status exp_status;
        start = 1'b1;
        i_start_time = lo;
        i_end_time = hi;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        exp_status = predict_booking(lo, hi);
        expected_status_q.insert(expected_status_q.size(), exp_status);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            case (o_status)
                irt_pkg::STATUS_BOOKED:  seen_booked++;
                irt_pkg::STATUS_OVERLAP: seen_overlap++;
                irt_pkg::STATUS_FULL:    seen_full++;
                default: ;
            endcase
            if (expected_status_q.size() == 0) begin
                $error("status: unexpected beat, actual %0d", o_status);
                error_count++;
            end else begin
                if (o_status !== expected_status_q[0]) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           expected_status_q[0], o_status);
                    error_count++;
                end
                void'(expected_status_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL interval_reservation_table");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_boundaries();
        send_request(32'd100, 32'd200);
        send_request(32'd0, 32'hFFFF_FFFF);
        send_request(32'd200, 32'd300);
        send_request(32'd50, 32'd100);
        send_request(32'd150, 32'd151);
        send_request(32'd299, 32'd301);
        send_request(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'd0, 32'd1);
        send_request(32'd99, 32'd101);
    endtask

    task automatic test_empty_and_reversed();
        send_request(32'd0, 32'd0);
        send_request(32'd150, 32'd150);
        send_request(32'd100, 32'd100);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'd1000, 32'd500);
        send_request(32'd250, 32'd10);
        send_request(32'hFFFF_FFFF, 32'd0);
        send_request(32'd400, 32'd600);
        send_request(32'd450, 32'd1200);
        send_request(32'd300, 32'd2000);
    endtask

    // mostly clashes with stored ranges and fresh bookings, plus empty, reversed and random ranges
    task automatic test_random_bookings(input int count);
        int unsigned    pick;
        int             idx;
        irt_pkg::t_time lo;
        irt_pkg::t_time hi;
        irt_pkg::t_time len;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99, 0);
            lo = $urandom;
            hi = $urandom;
            if (pick < 10) begin
                len = $urandom_range(64, 1);
                lo = fresh_base;
                hi = fresh_base + len;
                fresh_base = hi + $urandom_range(16, 0);
            end else if (pick < 60 && booked_count > 0) begin
                idx = $urandom_range(booked_count - 1, 0);
                if (booked_end[idx] != 0 && booked_start[idx] != 32'hFFFF_FFFF) begin
                    lo = $urandom_range(booked_end[idx] - 1, 0);
                    hi = $urandom_range(32'hFFFF_FFFF, booked_start[idx] + 1);
                end
            end else if (pick < 65) begin
                hi = lo;
            end else if (pick < 70) begin
                if (lo < hi) begin
                    len = lo;
                    lo = hi;
                    hi = len;
                end
            end
            send_request(lo, hi);
            if ($urandom_range(3, 0) == 0) begin
                idle_gap($urandom_range(19, 1));
            end
        end
    endtask

    task automatic test_back_to_back(input int count);
        int             idx;
        irt_pkg::t_time lo;
        irt_pkg::t_time hi;
        for (int n = 0; n < count; n++) begin
            lo = $urandom;
            hi = $urandom;
            if (n % 2 == 0 && booked_count > 0) begin
                idx = $urandom_range(booked_count - 1, 0);
                lo = booked_start[idx];
                hi = booked_end[idx];
            end else if (n % 3 == 0) begin
                lo = fresh_base;
                hi = fresh_base + 1;
                fresh_base = fresh_base + 2;
            end
            send_request(lo, hi);
        end
        start = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_start_time = '0;
        i_end_time = '0;
        booked_count = 0;
        fresh_base = 32'h4000_0000;
        error_count = 0;
        requests_sent = 0;
        seen_booked = 0;
        seen_overlap = 0;
        seen_full = 0;
        idle_cycles = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_boundaries();
        test_empty_and_reversed();
        test_random_bookings(780);
        test_back_to_back(150);

        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 4) @(posedge i_clk);

        $display("covered %0d requests: %0d booked, %0d refused on overlap, %0d refused as full",
                 requests_sent, seen_booked, seen_overlap, seen_full);
        $display("table ended holding %0d of %0d ranges", booked_count, CAPACITY);
        if (error_count == 0) begin
            $display("PASS interval_reservation_table");
        end else begin
            $display("FAIL interval_reservation_table");
        end
        $finish;
    end

endmodule
